>>> hw/rtl/tcsw_pkg.sv
// Package for the terminal character screen writer.
// Holds character codes, command and state types shared by the RTL modules.
// No dependencies.
`timescale 1ns / 1ps

package tcsw_pkg;

  // Default screen geometry
  localparam int unsigned TCSW_COLS = 32;
  localparam int unsigned TCSW_ROWS = 16;

  // Depths of the command queue and the result queue
  localparam int unsigned TCSW_CMD_DEPTH = 4;
  localparam int unsigned TCSW_RES_DEPTH = 4;

  // Opcodes
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  // What the back end does to the screen memory for one command
  typedef enum logic [1:0] {
    K_NOP,
    K_WRITE,
    K_READ
  } cmd_kind_t;

  // Control part of one queued command
  typedef struct packed {
    cmd_kind_t kind;
    logic      clr;       // blank one row after the main access
    logic      scrolled;  // result field
    logic      esc;       // result field
  } cmd_ctl_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_CLR
  } bk_state_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic init_busy;
  } bk_stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage

>>> hw/rtl/tcsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcsw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tcsw_fifo.sv
// Small synchronous FIFO with occupancy count, used for the command and result queues.
// No dependencies.
`timescale 1ns / 1ps

module tcsw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH) + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CNTW-1:0]  count
);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wptr_r] <= din;
    end
  end

  assign dout  = data_r[rptr_r];
  assign count = cnt_r;

endmodule

>>> hw/rtl/tcsw_front.sv
// Front end: cursor, escape and previous-byte tracking; classifies each item into
// a screen memory command with physical row addresses. Uses tcsw_pkg.
`timescale 1ns / 1ps

module tcsw_front
  import tcsw_pkg::*;
#(
  parameter int unsigned COLS = TCSW_COLS,
  parameter int unsigned ROWS = TCSW_ROWS,
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned RW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          opcode,
  input  logic [7:0]    char_in,
  input  logic [RW-1:0] read_row,
  input  logic [CW-1:0] read_col,
  output cmd_ctl_t      q_ctl,
  output logic [RW-1:0] q_row,
  output logic [CW-1:0] q_col,
  output logic [7:0]    q_char,
  output logic [RW-1:0] q_crow,
  output logic [CW-1:0] q_cur_col,
  output logic [RW-1:0] q_cur_row
);

  logic [CW-1:0] x_r, x_nxt;
  logic [RW-1:0] y_r, y_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          esc_r, esc_nxt;

  logic [RW:0]   cur_sum, rd_sum;
  logic [RW-1:0] cur_phys, rd_phys, top_inc;
  logic          last_row, last_col, rd_ok, swallow;

  // Ring mapping of logical rows onto physical memory rows
  assign cur_sum  = {1'b0, y_r} + {1'b0, top_r};
  assign cur_phys = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS)) : RW'(cur_sum);
  assign rd_sum   = {1'b0, read_row} + {1'b0, top_r};
  assign rd_phys  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS)) : RW'(rd_sum);
  assign top_inc  = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
  assign last_row = (y_r == RW'(ROWS - 1));
  assign last_col = (x_r == CW'(COLS - 1));
  assign rd_ok    = ({1'b0, read_row} < (RW+1)'(ROWS)) && ({1'b0, read_col} < (CW+1)'(COLS));
  assign swallow  = (char_in == CH_CR && prev_r == CH_LF) ||
                    (char_in == CH_LF && prev_r == CH_CR);

  always_comb begin
    x_nxt          = x_r;
    y_nxt          = y_r;
    top_nxt        = top_r;
    prev_nxt       = prev_r;
    esc_nxt        = esc_r;
    q_ctl.kind     = K_NOP;
    q_ctl.clr      = 1'b0;
    q_ctl.scrolled = 1'b0;
    q_row          = cur_phys;
    q_col          = x_r;
    q_crow         = top_r;
    if (opcode == OP_READ) begin
      if (rd_ok) begin
        q_ctl.kind = K_READ;
        q_row      = rd_phys;
        q_col      = read_col;
      end
    end else if (char_in == CH_ESC || esc_r) begin
      esc_nxt  = !is_letter(char_in);
      prev_nxt = char_in;
    end else if (!swallow) begin
      prev_nxt = char_in;
      if (char_in == CH_CR || char_in == CH_LF) begin
        x_nxt = '0;
        if (last_row) begin
          q_ctl.clr      = 1'b1;
          q_ctl.scrolled = 1'b1;
          top_nxt        = top_inc;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end else if (char_in == CH_BS) begin
        if (x_r != '0) begin
          x_nxt = x_r - 1'b1;
        end else begin
          x_nxt = CW'(COLS - 1);
          if (y_r != '0) begin
            y_nxt = y_r - 1'b1;
          end
        end
      end else if (char_in >= CH_SPACE && char_in <= CH_TILDE) begin
        q_ctl.kind = K_WRITE;
        if (last_col) begin
          x_nxt = '0;
          if (last_row) begin
            // old top row becomes the blank bottom row
            q_ctl.clr      = 1'b1;
            q_ctl.scrolled = 1'b1;
            top_nxt        = top_inc;
          end else begin
            y_nxt = y_r + 1'b1;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
    end
    q_ctl.esc = esc_nxt;
  end

  assign q_char    = char_in;
  assign q_cur_col = x_nxt;
  assign q_cur_row = y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      top_r  <= '0;
      prev_r <= '0;
      esc_r  <= 1'b0;
    end else if (acc) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      top_r  <= top_nxt;
      prev_r <= prev_nxt;
      esc_r  <= esc_nxt;
    end
  end

endmodule

>>> hw/rtl/tcsw_back.sv
// Back end: executes queued commands on the screen memory, runs the reset clear
// and the row blanking after a scroll, and produces results. Uses tcsw_pkg.
`timescale 1ns / 1ps

module tcsw_back
  import tcsw_pkg::*;
#(
  parameter int unsigned COLS = TCSW_COLS,
  parameter int unsigned ROWS = TCSW_ROWS,
  parameter int unsigned RES_DEPTH = TCSW_RES_DEPTH,
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned CNTW = $clog2(RES_DEPTH) + 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  output logic            q_pop,
  input  cmd_ctl_t        q_ctl,
  input  logic [RW-1:0]   q_row,
  input  logic [CW-1:0]   q_col,
  input  logic [7:0]      q_char,
  input  logic [RW-1:0]   q_crow,
  input  logic [CW-1:0]   q_cur_col,
  input  logic [RW-1:0]   q_cur_row,
  input  logic [CNTW-1:0] res_count,
  output logic            ram_we,
  output logic [RW+CW-1:0] ram_waddr,
  output logic [7:0]      ram_wdata,
  output logic [RW+CW-1:0] ram_raddr,
  input  logic [7:0]      ram_rdata,
  output logic            res_push,
  output logic [7:0]      res_cell,
  output logic [CW-1:0]   res_col,
  output logic [RW-1:0]   res_row,
  output logic            res_scr,
  output logic            res_esc,
  output bk_stat_t        stat
);

  bk_state_t     state_r, state_nxt;
  logic [RW-1:0] sw_row_r, sw_row_nxt;
  logic [CW-1:0] sw_col_r, sw_col_nxt;
  logic          pend_r, pend_nxt;
  logic          rd_r, rd_nxt;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          scr_r, esc_r;
  logic [CNTW:0] used;
  logic          credit, issue, col_last, row_last;

  // Room in the result queue counts the result still in the read stage
  assign used     = {1'b0, res_count} + (CNTW+1)'(pend_r);
  assign credit   = used < (CNTW+1)'(RES_DEPTH);
  assign issue    = (state_r == BK_RUN) && !q_empty && credit;
  assign col_last = (sw_col_r == CW'(COLS - 1));
  assign row_last = (sw_row_r == RW'(ROWS - 1));

  // Next state
  always_comb begin
    state_nxt  = state_r;
    sw_row_nxt = sw_row_r;
    sw_col_nxt = sw_col_r;
    unique case (state_r)
      BK_INIT: begin
        if (col_last) begin
          sw_col_nxt = '0;
          if (row_last) begin
            state_nxt  = BK_RUN;
            sw_row_nxt = '0;
          end else begin
            sw_row_nxt = sw_row_r + 1'b1;
          end
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end
      BK_RUN: begin
        if (issue && q_ctl.clr) begin
          state_nxt  = BK_CLR;
          sw_row_nxt = q_crow;
          sw_col_nxt = '0;
        end
      end
      BK_CLR: begin
        if (col_last) begin
          state_nxt  = BK_RUN;
          sw_col_nxt = '0;
        end else begin
          sw_col_nxt = sw_col_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_INIT;
      end
    endcase
  end

  // Outputs
  always_comb begin
    q_pop     = issue;
    pend_nxt  = issue;
    rd_nxt    = issue && (q_ctl.kind == K_READ);
    ram_raddr = {q_row, q_col};
    ram_we    = 1'b0;
    ram_waddr = {q_row, q_col};
    ram_wdata = q_char;
    unique case (state_r)
      BK_INIT, BK_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = {sw_row_r, sw_col_r};
        ram_wdata = CH_SPACE;
      end
      BK_RUN: begin
        ram_we = issue && (q_ctl.kind == K_WRITE);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_INIT;
      sw_row_r <= '0;
      sw_col_r <= '0;
      pend_r   <= 1'b0;
      rd_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sw_row_r <= sw_row_nxt;
      sw_col_r <= sw_col_nxt;
      pend_r   <= pend_nxt;
      rd_r     <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      col_r <= q_cur_col;
      row_r <= q_cur_row;
      scr_r <= q_ctl.scrolled;
      esc_r <= q_ctl.esc;
    end
  end

  assign res_push       = pend_r;
  assign res_cell       = rd_r ? ram_rdata : 8'h00;
  assign res_col        = col_r;
  assign res_row        = row_r;
  assign res_scr        = scr_r;
  assign res_esc        = esc_r;
  assign stat.init_busy = (state_r == BK_INIT);

endmodule

>>> hw/rtl/terminal_char_screen_writer.sv
// Terminal character screen writer: keeps a ROWS x COLS text screen fed by
// received bytes, with cursor, scrolling and escape absorption, and answers
// single-cell reads. One item is accepted per clock cycle while in_full is low; every item
// gives exactly one result, in order, through a result queue. After reset the
// screen memory is swept to spaces one cell per cycle and in_full stays high
// until it is done. A scroll blanks the new bottom row in the back end; the
// command queue takes up to TCSW_CMD_DEPTH items meanwhile, after which in_full
// rises until the blanking ends. Results then stream at one per cycle again
// while the result queue has room.
`timescale 1ns / 1ps

module terminal_char_screen_writer
  import tcsw_pkg::*;
#(
  parameter int unsigned COLS = TCSW_COLS,
  parameter int unsigned ROWS = TCSW_ROWS,
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned RW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst_n,
  // input queue side
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_opcode,
  input  logic [7:0]    in_char_in,
  input  logic [RW-1:0] in_read_row,
  input  logic [CW-1:0] in_read_col,
  // result queue side
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_cell_data,
  output logic [CW-1:0] out_cursor_col,
  output logic [RW-1:0] out_cursor_row,
  output logic          out_scrolled,
  output logic          out_escape_active
);

  // Command entry: control, address row/col, char, clear row, cursor after item
  localparam int unsigned CMDW = $bits(cmd_ctl_t) + RW + CW + 8 + RW + CW + RW;
  localparam int unsigned RESW = 8 + CW + RW + 2;
  localparam int unsigned CNTW = $clog2(TCSW_RES_DEPTH) + 1;
  localparam int unsigned CCNTW = $clog2(TCSW_CMD_DEPTH) + 1;

  // front end outputs
  cmd_ctl_t      f_ctl;
  logic [RW-1:0] f_row, f_crow, f_cur_row;
  logic [CW-1:0] f_col, f_cur_col;
  logic [7:0]    f_char;

  // command queue
  logic            cq_full, cq_empty, cq_pop;
  logic [CMDW-1:0] cq_din, cq_dout;
  logic [CCNTW-1:0] cq_count;

  // command queue head as seen by the back end
  cmd_ctl_t      b_ctl;
  logic [RW-1:0] b_row, b_crow, b_cur_row;
  logic [CW-1:0] b_col, b_cur_col;
  logic [7:0]    b_char;

  // screen memory
  logic             ram_we;
  logic [RW+CW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // result path
  logic            res_push, res_full, res_scr, res_esc;
  logic [7:0]      res_cell;
  logic [CW-1:0]   res_col;
  logic [RW-1:0]   res_row;
  logic [RESW-1:0] rq_din, rq_dout;
  logic [CNTW-1:0] rq_count;

  bk_stat_t bk_stat;
  logic     in_xfer;

  // No input transfer while the reset clear sweep runs
  assign in_full = cq_full || bk_stat.init_busy;
  assign in_xfer = in_push && !in_full;

  tcsw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_xfer),
    .opcode    (in_opcode),
    .char_in   (in_char_in),
    .read_row  (in_read_row),
    .read_col  (in_read_col),
    .q_ctl     (f_ctl),
    .q_row     (f_row),
    .q_col     (f_col),
    .q_char    (f_char),
    .q_crow    (f_crow),
    .q_cur_col (f_cur_col),
    .q_cur_row (f_cur_row)
  );

  assign cq_din = {f_ctl, f_row, f_col, f_char, f_crow, f_cur_col, f_cur_row};

  // Short queue that decouples classification from memory work
  tcsw_fifo #(
    .WIDTH (CMDW),
    .DEPTH (TCSW_CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_xfer),
    .din   (cq_din),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty),
    .count (cq_count)
  );

  assign {b_ctl, b_row, b_col, b_char, b_crow, b_cur_col, b_cur_row} = cq_dout;

  tcsw_back #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .RES_DEPTH (TCSW_RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (cq_empty),
    .q_pop     (cq_pop),
    .q_ctl     (b_ctl),
    .q_row     (b_row),
    .q_col     (b_col),
    .q_char    (b_char),
    .q_crow    (b_crow),
    .q_cur_col (b_cur_col),
    .q_cur_row (b_cur_row),
    .res_count (rq_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_push  (res_push),
    .res_cell  (res_cell),
    .res_col   (res_col),
    .res_row   (res_row),
    .res_scr   (res_scr),
    .res_esc   (res_esc),
    .stat      (bk_stat)
  );

  // Screen memory, addressed {physical row, column}
  tcsw_ram #(
    .WIDTH (8),
    .DEPTH (ROWS << CW)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rq_din = {res_cell, res_col, res_row, res_scr, res_esc};

  // Result queue; the back end only issues when a slot is reserved, so a push
  // never meets a full queue
  tcsw_fifo #(
    .WIDTH (RESW),
    .DEPTH (TCSW_RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (rq_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty),
    .count (rq_count)
  );

  assign {out_cell_data, out_cursor_col, out_cursor_row, out_scrolled,
          out_escape_active} = rq_dout;

endmodule

>>> hw/rtl/tcsw_checker.sv
// Port-level checker for the terminal character screen writer, bound to the top level.
// Uses tcsw_pkg for the default geometry.
`timescale 1ns / 1ps

module tcsw_checker
  import tcsw_pkg::*;
#(
  parameter int unsigned COLS = TCSW_COLS,
  parameter int unsigned ROWS = TCSW_ROWS,
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned RW = $clog2(ROWS)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input logic [7:0]    out_cell_data,
  input logic [CW-1:0] out_cursor_col,
  input logic [RW-1:0] out_cursor_row,
  input logic          out_scrolled,
  input logic          out_escape_active
);

  // Reset starts the clear sweep: nothing is taken in
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted right after reset");

  // Reset drops all results
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ({1'b0, out_cursor_row} < (RW+1)'(ROWS)) &&
                   ({1'b0, out_cursor_col} < (CW+1)'(COLS)))
    else $error("cursor outside the screen");

  // A scroll, by line feed or by wrap, leaves the cursor on the last row at column 0
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_scrolled) |-> (out_cursor_row == RW'(ROWS - 1)) &&
                                     (out_cursor_col == '0) && (out_cell_data == 8'h00))
    else $error("scroll result inconsistent");

  // A waiting result stays put until it is popped
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty &&
      $stable({out_cell_data, out_cursor_col, out_cursor_row, out_scrolled,
               out_escape_active}))
    else $error("waiting result changed");

endmodule

bind terminal_char_screen_writer tcsw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcsw_checker (.*);
